// ----- src/indexed_list_store_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list store
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define ILS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define ILS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- src/ils_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed list store package
// Types, codes and sizes shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

  localparam int unsigned Depth  = 64;
  localparam int unsigned IdxW   = $clog2(Depth);
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned PosW   = 7;
  localparam int unsigned DataW  = 32;
  localparam int unsigned EntryW = 7;

  typedef enum logic [3:0] {
    ReqRead      = 4'd0,
    ReqPushFront = 4'd1,
    ReqPushBack  = 4'd2,
    ReqInsertAt  = 4'd3,
    ReqPopFront  = 4'd4,
    ReqPopBack   = 4'd5,
    ReqRemoveAt  = 4'd6,
    ReqDump      = 4'd7,
    ReqDumpRev   = 4'd8
  } req_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadIndex = 2'd1,
    StEmpty    = 2'd2,
    StFull     = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]              req_type;
    logic signed [DataW-1:0] item_value;
    logic [PosW-1:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] data_out;
    logic [1:0]              status;
    logic [EntryW-1:0]       entry_count;
    logic                    last_of_run;
  } rsp_t;

  typedef struct packed {
    logic    load;
    logic    ptr_init;
    logic    rd_en;
    logic    wr_shift;
    logic    finish;
    logic    dump_step;
    logic    emit;
    logic    emit_data;
    status_e emit_status;
    logic    emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_insert;
    logic is_remove;
    logic is_dump;
    logic full;
    logic empty;
    logic bad_idx;
    logic more_shift;
    logic dump_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- src/indexed_list_store.sv -----
// ----------------------------------------------------------------------------
// Indexed list store
// A rejected or unknown request gives its result straight from the decision state, a
// read after one memory read, and an insert or remove that moves k entries after a read
// and a write step for each. A dump gives one result per memory read, in order, bound
// by the single memory read port.
// The next request is taken at the edge of the final result; results never stall.
// Reset idles the controller and clears the count; entries are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire ils_pkg::req_t  req_i,
  output ils_pkg::rsp_t       rsp_o,
  output logic                rsp_valid_o
);

  ils_pkg::ctrl_cmd_t  cmd;
  ils_pkg::dp_status_t dp_st;

  ils_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .st_i   (dp_st),
    .cmd_o  (cmd)
  );

  ils_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .st_o        (dp_st),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

endmodule

`default_nettype wire

// ----- src/ils_ctrl.sv -----
// ----------------------------------------------------------------------------
// Indexed list store controller
// Sequences checks, shift steps, reads and result emission for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire ils_pkg::dp_status_t st_i,
  output ils_pkg::ctrl_cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    StIdle    = 7'b0000001,
    StDecide  = 7'b0000010,
    StShChk   = 7'b0000100,
    StShWr    = 7'b0001000,
    StRdWait  = 7'b0010000,
    StDumpRd  = 7'b0100000,
    StDumpOut = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != StIdle);

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.emit_status = ils_pkg::StOk;
    cmd_o.emit_last   = 1'b1;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = StDecide;
        end
      end
      StDecide: begin
        cmd_o.ptr_init = 1'b1;
        state_d        = StIdle;
        if (st_i.is_read) begin
          if (st_i.bad_idx) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ils_pkg::StBadIndex;
          end else begin
            cmd_o.rd_en = 1'b1;
            state_d     = StRdWait;
          end
        end else if (st_i.is_insert) begin
          if (st_i.full) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ils_pkg::StFull;
          end else if (st_i.bad_idx) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ils_pkg::StBadIndex;
          end else begin
            state_d = StShChk;
          end
        end else if (st_i.is_remove) begin
          if (st_i.empty) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ils_pkg::StEmpty;
          end else if (st_i.bad_idx) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ils_pkg::StBadIndex;
          end else begin
            state_d = StShChk;
          end
        end else if (st_i.is_dump) begin
          if (st_i.empty) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ils_pkg::StEmpty;
          end else begin
            state_d = StDumpRd;
          end
        end else begin
          cmd_o.emit = 1'b1;
        end
      end
      StShChk: begin
        if (st_i.more_shift) begin
          cmd_o.rd_en = 1'b1;
          state_d     = StShWr;
        end else begin
          cmd_o.finish = 1'b1;
          cmd_o.emit   = 1'b1;
          state_d      = StIdle;
        end
      end
      StShWr: begin
        cmd_o.wr_shift = 1'b1;
        state_d        = StShChk;
      end
      StRdWait: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_data = 1'b1;
        state_d         = StIdle;
      end
      StDumpRd: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StDumpOut;
      end
      StDumpOut: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_data = 1'b1;
        cmd_o.emit_last = st_i.dump_last;
        cmd_o.dump_step = 1'b1;
        state_d         = st_i.dump_last ? StIdle : StDumpRd;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/ils_dp.sv -----
// ----------------------------------------------------------------------------
// Indexed list store datapath
// Entry memory, entry count, shift pointer, request register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_store_defines.svh"

module ils_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ils_pkg::req_t      req_i,
  input  wire ils_pkg::ctrl_cmd_t cmd_i,
  output ils_pkg::dp_status_t     st_o,
  output ils_pkg::rsp_t           rsp_o,
  output logic                    rsp_valid_o
);

  localparam int unsigned PosW = ils_pkg::PosW;
  localparam int unsigned IdxW = ils_pkg::IdxW;
  localparam int unsigned CntW = ils_pkg::CntW;

  ils_pkg::req_t                 req_q;
  logic [ils_pkg::DataW-1:0]     mem_q [ils_pkg::Depth];
  logic [ils_pkg::DataW-1:0]     rdata_q;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic [PosW-1:0]               ptr_q, ptr_d;
  ils_pkg::rsp_t                 rsp_q, rsp_d;
  logic                          rsp_valid_q;

  logic [PosW-1:0]               cnt_w;
  logic [PosW-1:0]               eff_pos;
  logic [PosW-1:0]               rd_addr;
  logic [PosW-1:0]               wr_addr;
  logic [ils_pkg::DataW-1:0]     wr_data;
  logic                          wr_en;
  logic                          dump_rev;
  logic [PosW:0]                 ptr_inc;

  assign cnt_w   = PosW'(cnt_q);
  assign ptr_inc = {1'b0, ptr_q} + (PosW+1)'(1);

  always_comb begin
    st_o.is_read   = 1'b0;
    st_o.is_insert = 1'b0;
    st_o.is_remove = 1'b0;
    st_o.is_dump   = 1'b0;
    dump_rev       = 1'b0;
    eff_pos        = req_q.position;
    unique case (req_q.req_type) inside
      ils_pkg::ReqRead: begin
        st_o.is_read = 1'b1;
      end
      ils_pkg::ReqPushFront: begin
        st_o.is_insert = 1'b1;
        eff_pos        = '0;
      end
      ils_pkg::ReqPushBack: begin
        st_o.is_insert = 1'b1;
        eff_pos        = cnt_w;
      end
      ils_pkg::ReqInsertAt: begin
        st_o.is_insert = 1'b1;
      end
      ils_pkg::ReqPopFront: begin
        st_o.is_remove = 1'b1;
        eff_pos        = '0;
      end
      ils_pkg::ReqPopBack: begin
        st_o.is_remove = 1'b1;
        eff_pos        = cnt_w - PosW'(1);
      end
      ils_pkg::ReqRemoveAt: begin
        st_o.is_remove = 1'b1;
      end
      ils_pkg::ReqDump: begin
        st_o.is_dump = 1'b1;
      end
      ils_pkg::ReqDumpRev: begin
        st_o.is_dump = 1'b1;
        dump_rev     = 1'b1;
      end
      default: begin
        eff_pos = req_q.position;
      end
    endcase

    st_o.full       = (cnt_q == CntW'(ils_pkg::Depth));
    st_o.empty      = (cnt_q == '0);
    st_o.bad_idx    = 1'b0;
    st_o.more_shift = 1'b0;
    if (st_o.is_read) begin
      st_o.bad_idx = (req_q.position >= cnt_w);
    end else if (st_o.is_insert) begin
      st_o.bad_idx    = (eff_pos > cnt_w);
      st_o.more_shift = (ptr_q > eff_pos);
    end else if (st_o.is_remove) begin
      st_o.bad_idx    = (eff_pos >= cnt_w);
      st_o.more_shift = (ptr_inc < {1'b0, cnt_w});
    end
    st_o.dump_last = (ptr_inc == {1'b0, cnt_w});
  end

  always_comb begin
    if (st_o.is_read) begin
      rd_addr = req_q.position;
    end else if (st_o.is_insert) begin
      rd_addr = ptr_q - PosW'(1);
    end else if (st_o.is_remove) begin
      rd_addr = ptr_inc[PosW-1:0];
    end else if (dump_rev) begin
      rd_addr = cnt_w - PosW'(1) - ptr_q;
    end else begin
      rd_addr = ptr_q;
    end
  end

  assign wr_en   = cmd_i.wr_shift | (cmd_i.finish & st_o.is_insert);
  assign wr_addr = cmd_i.wr_shift ? ptr_q : eff_pos;
  assign wr_data = cmd_i.wr_shift ? rdata_q : req_q.item_value;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr[IdxW-1:0]] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr[IdxW-1:0]];
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_init) begin
      if (st_o.is_insert) begin
        ptr_d = cnt_w;
      end else if (st_o.is_remove) begin
        ptr_d = eff_pos;
      end else begin
        ptr_d = '0;
      end
    end else if (cmd_i.wr_shift) begin
      ptr_d = st_o.is_insert ? (ptr_q - PosW'(1)) : ptr_inc[PosW-1:0];
    end else if (cmd_i.dump_step) begin
      ptr_d = ptr_inc[PosW-1:0];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.finish) begin
      cnt_d = st_o.is_insert ? (cnt_q + CntW'(1)) : (cnt_q - CntW'(1));
    end
  end

  always_comb begin
    rsp_d             = rsp_q;
    rsp_d.data_out    = cmd_i.emit_data ? rdata_q : '0;
    rsp_d.status      = cmd_i.emit_status;
    rsp_d.entry_count = ils_pkg::EntryW'(cnt_d);
    rsp_d.last_of_run = cmd_i.emit_last;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.emit) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      rsp_valid_q <= cmd_i.emit;
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  `ILS_ASSERT(a_cnt_bound, cnt_q <= CntW'(ils_pkg::Depth), "Entry count exceeds depth.")
  `ILS_ASSERT_IMP(a_no_full_insert, cmd_i.finish && st_o.is_insert, !st_o.full, "Insert completed on a full list.")
  `ILS_ASSERT_IMP(a_no_empty_remove, cmd_i.finish && st_o.is_remove, !st_o.empty, "Remove completed on an empty list.")
  `ILS_ASSERT_IMP(a_shift_in_range, cmd_i.wr_shift, ptr_q <= cnt_w, "Shift write past the list end.")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Indexed list store testbench
// Sends read, insert, remove, dump and unknown requests through the start/busy
// command port, keeps its own copy of the list, and checks every result
// transaction field by field against the list it predicts.
// ----------------------------------------------------------------------------
module tb;

  localparam int                               DataW         = ils_pkg::DataW;
  localparam int                               Depth         = ils_pkg::Depth;
  localparam int                               PosW          = ils_pkg::PosW;
  localparam int                               EntryW        = ils_pkg::EntryW;
  localparam logic [3:0]                       ReqUnknownLo  = 4'd9;
  localparam logic [3:0]                       ReqUnknownHi  = 4'd15;
  localparam logic signed [ils_pkg::DataW-1:0] ValMax        = 32'sh7fffffff;
  localparam logic signed [ils_pkg::DataW-1:0] ValMin        = 32'sh80000000;
  localparam int                               PosMax        = 127;
  localparam int                               RandomItems   = 360;
  localparam int                               WatchdogLimit = 4000;

  typedef struct {
    ils_pkg::req_t req;
    int unsigned   gap;
    bit            drain;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  ils_pkg::req_t req = '0;
  ils_pkg::rsp_t rsp;
  logic rsp_valid;

  stim_t                   stim_q[$];
  ils_pkg::rsp_t           due_rsp_q[$];
  logic signed [DataW-1:0] list_model[$];

  int  error_count = 0;
  int  n_accepted = 0;
  int  n_results = 0;
  int  n_full = 0;
  int  n_empty = 0;
  int  n_bad_index = 0;
  int  peak_fill = 0;
  int  idle_cycles = 0;
  int  gap_left = 0;
  bit  gap_armed = 1'b0;
  bit  gap_free = 1'b0;
  bit  fire;
  bit  go;
  stim_t nxt;

  indexed_list_store u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .rsp_o       (rsp),
    .rsp_valid_o (rsp_valid)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic ils_pkg::status_e list_insert(input int pos,
                                                   input logic signed [DataW-1:0] val);
    if (list_model.size() >= Depth) return ils_pkg::StFull;
    if (pos > list_model.size()) return ils_pkg::StBadIndex;
    list_model.insert(pos, val);
    return ils_pkg::StOk;
  endfunction

  function automatic ils_pkg::status_e list_remove(input int pos);
    if (list_model.size() == 0) return ils_pkg::StEmpty;
    if (pos >= list_model.size()) return ils_pkg::StBadIndex;
    list_model.delete(pos);
    return ils_pkg::StOk;
  endfunction

  function automatic void apply_list_request(input ils_pkg::req_t r);
    ils_pkg::rsp_t    e;
    ils_pkg::status_e st;
    int               pos;
    int               fill;
    e = '0;
    st = ils_pkg::StOk;
    pos = int'(r.position);
    case (r.req_type)
      ils_pkg::ReqRead: begin
        if (pos < list_model.size()) e.data_out = list_model[pos];
        else st = ils_pkg::StBadIndex;
      end
      ils_pkg::ReqPushFront: st = list_insert(0, r.item_value);
      ils_pkg::ReqPushBack:  st = list_insert(list_model.size(), r.item_value);
      ils_pkg::ReqInsertAt:  st = list_insert(pos, r.item_value);
      ils_pkg::ReqPopFront:  st = list_remove(0);
      ils_pkg::ReqPopBack:
        st = list_remove(list_model.size() == 0 ? 0 : list_model.size() - 1);
      ils_pkg::ReqRemoveAt:  st = list_remove(pos);
      ils_pkg::ReqDump, ils_pkg::ReqDumpRev: begin
        fill = list_model.size();
        if (fill == 0) begin
          st = ils_pkg::StEmpty;
        end else begin
          for (int i = 0; i < fill; i++) begin
            e.data_out    = (r.req_type == ils_pkg::ReqDump) ? list_model[i]
                                                             : list_model[fill - 1 - i];
            e.status      = ils_pkg::StOk;
            e.entry_count = EntryW'(fill);
            e.last_of_run = (i == fill - 1);
            due_rsp_q.push_back(e);
          end
          return;
        end
      end
      default: ;
    endcase
    case (st)
      ils_pkg::StFull:     n_full++;
      ils_pkg::StEmpty:    n_empty++;
      ils_pkg::StBadIndex: n_bad_index++;
      default: ;
    endcase
    if (list_model.size() > peak_fill) peak_fill = list_model.size();
    e.status      = st;
    e.entry_count = EntryW'(list_model.size());
    e.last_of_run = 1'b1;
    due_rsp_q.push_back(e);
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return ValMin;
      1:       return ValMax;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(input logic [3:0] kind, input logic signed [DataW-1:0] val,
                         input int pos, input bit drain);
    stim_t s;
    s.req.req_type   = kind;
    s.req.item_value = val;
    s.req.position   = PosW'(pos);
    s.gap            = gap_free ? 0 : $urandom_range(0, 16);
    s.drain          = drain;
    stim_q.push_back(s);
  endtask

  task automatic build_directed();
    add_req(ils_pkg::ReqRead, ValMax, 0, 1'b0);
    add_req(ils_pkg::ReqPopFront, 0, 0, 1'b0);
    add_req(ils_pkg::ReqPopBack, 0, 0, 1'b0);
    add_req(ils_pkg::ReqRemoveAt, 0, PosMax, 1'b0);
    add_req(ils_pkg::ReqDump, 0, 0, 1'b0);
    add_req(ils_pkg::ReqDumpRev, 0, 0, 1'b0);
    add_req(ils_pkg::ReqInsertAt, 5, 1, 1'b0);
    add_req(ils_pkg::ReqPushBack, ValMax, 0, 1'b0);
    add_req(ils_pkg::ReqPushFront, ValMin, PosMax, 1'b0);
    add_req(ils_pkg::ReqInsertAt, -1, 1, 1'b0);
    add_req(ils_pkg::ReqInsertAt, 7, 5, 1'b0);
    add_req(ils_pkg::ReqInsertAt, 0, 3, 1'b0);
    add_req(ils_pkg::ReqRead, 0, 0, 1'b0);
    add_req(ils_pkg::ReqRead, 0, 3, 1'b0);
    add_req(ils_pkg::ReqRead, 0, 4, 1'b0);
    add_req(ils_pkg::ReqRead, 0, PosMax, 1'b0);
    add_req(ils_pkg::ReqDump, 0, 0, 1'b0);
    add_req(ils_pkg::ReqDumpRev, 0, 0, 1'b0);
    add_req(ils_pkg::ReqRemoveAt, 0, 4, 1'b0);
    add_req(ils_pkg::ReqRemoveAt, 0, 1, 1'b0);
    add_req(ils_pkg::ReqPopFront, 0, 0, 1'b0);
    add_req(ils_pkg::ReqPopBack, 0, 0, 1'b0);
    add_req(ReqUnknownLo, ValMin, PosMax, 1'b0);
    add_req(ReqUnknownHi, ValMax, 0, 1'b1);
    add_req(ils_pkg::ReqRemoveAt, 0, 0, 1'b1);
  endtask

  task automatic build_random();
    int         est;
    int         pos;
    int         roll;
    int         edge_tries;
    bit         growing;
    bit         do_insert;
    logic [3:0] kind;
    est = 0;
    edge_tries = 0;
    growing = 1'b1;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 30 == 0) gap_free = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        roll = $urandom_range(0, 14);
        if (roll < 7) kind = ils_pkg::ReqRead;
        else if (roll < 10) kind = ils_pkg::ReqDump;
        else if (roll < 13) kind = ils_pkg::ReqDumpRev;
        else kind = 4'($urandom_range(ReqUnknownLo, ReqUnknownHi));
        pos = (est > 0) ? $urandom_range(0, est - 1) : 0;
      end else begin
        do_insert = growing ? (roll < 95) : (roll >= 95);
        if (do_insert) begin
          case ($urandom_range(0, 2))
            0:       kind = ils_pkg::ReqPushFront;
            1:       kind = ils_pkg::ReqPushBack;
            default: kind = ils_pkg::ReqInsertAt;
          endcase
          pos = $urandom_range(0, est);
        end else begin
          case ($urandom_range(0, 2))
            0:       kind = ils_pkg::ReqPopFront;
            1:       kind = ils_pkg::ReqPopBack;
            default: kind = ils_pkg::ReqRemoveAt;
          endcase
          pos = (est > 0) ? $urandom_range(0, est - 1) : 0;
        end
      end
      if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, PosMax);
      if (kind inside {ils_pkg::ReqPushFront, ils_pkg::ReqPushBack, ils_pkg::ReqInsertAt}) begin
        if (est == Depth && growing) edge_tries++;
        if (est < Depth && (kind != ils_pkg::ReqInsertAt || pos <= est)) est++;
      end else if (kind inside {ils_pkg::ReqPopFront, ils_pkg::ReqPopBack,
                                ils_pkg::ReqRemoveAt}) begin
        if (est == 0 && !growing) edge_tries++;
        if (est > 0 && (kind != ils_pkg::ReqRemoveAt || pos < est)) est--;
      end
      if (edge_tries >= 3) begin
        growing = !growing;
        edge_tries = 0;
      end
      add_req(kind, pick_value(), pos, $urandom_range(0, 39) == 0);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req <= '0;
      gap_left = 0;
      gap_armed = 1'b0;
    end else begin
      fire = start && !busy;
      go = 1'b0;
      if (fire) begin
        apply_list_request(req);
        n_accepted++;
      end
      if (start && !fire) begin
        go = 1'b1;
      end else if (stim_q.size() > 0) begin
        if (!gap_armed) begin
          gap_left = stim_q[0].gap;
          gap_armed = 1'b1;
        end
        if (stim_q[0].drain && due_rsp_q.size() > 0) begin
          go = 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          nxt = stim_q.pop_front();
          req <= nxt.req;
          gap_armed = 1'b0;
          go = 1'b1;
        end
      end
      start <= go;
    end
  end

  always @(posedge clk_i) begin
    ils_pkg::rsp_t exp_rsp;
    if (rst_ni && rsp_valid) begin
      n_results++;
      if (due_rsp_q.size() == 0) begin
        $display("%0t: result transaction with none expected, got %p", $time, rsp);
        error_count++;
      end else begin
        exp_rsp = due_rsp_q.pop_front();
        if (rsp.data_out !== exp_rsp.data_out) begin
          $display("%0t: data_out expected %0d got %0d", $time, exp_rsp.data_out, rsp.data_out);
          error_count++;
        end
        if (rsp.status !== exp_rsp.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_rsp.status, rsp.status);
          error_count++;
        end
        if (rsp.entry_count !== exp_rsp.entry_count) begin
          $display("%0t: entry_count expected %0d got %0d", $time, exp_rsp.entry_count,
                   rsp.entry_count);
          error_count++;
        end
        if (rsp.last_of_run !== exp_rsp.last_of_run) begin
          $display("%0t: last_of_run expected %0d got %0d", $time, exp_rsp.last_of_run,
                   rsp.last_of_run);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || rsp_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    build_directed();
    build_random();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    while (stim_q.size() > 0 || start) @(posedge clk_i);
    while (due_rsp_q.size() > 0) @(posedge clk_i);
    repeat (2 * Depth + 8) @(posedge clk_i);
    $display("Served %0d requests and checked %0d results, peak list fill %0d of %0d.",
             n_accepted, n_results, peak_fill, Depth);
    $display("Rejected requests: %0d full, %0d empty, %0d bad index.",
             n_full, n_empty, n_bad_index);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
